FILE: rtl/lzwbc_pkg.sv
package lzwbc_pkg;

	localparam int CODE_BITS_DEF = 12;
	localparam int FIRST_ENTRY   = 256;
	localparam int LIMIT_BITS    = 13;
	localparam int LIMIT_RESET   = 4096;
	localparam int EPOCH_BITS    = 8;
	localparam int APB_ADDR_BITS = 2;
	localparam logic [APB_ADDR_BITS-1:0] REG_DICT_LIMIT = 2'd0;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_HT,
		ST_DIC,
		ST_EMIT
	} lzwbc_state_t;

endpackage

FILE: rtl/lzw_byte_compressor_unit.sv
// LZW byte compressor.
// Input stream: s_axis_tdata carries one byte, s_axis_tlast marks the last byte
// of a text. Output stream: m_axis_tdata carries one code, m_axis_tlast marks
// the final code of a text. Each byte yields zero, one or two codes.
// The dictionary lives in a code memory (entry = prefix code and byte) plus an
// open-addressed hash table of twice the code space that maps a key to a code.
// Each table slot carries the epoch of the text that wrote it; a slot counts
// only if its epoch is the current one, so a new text just bumps the epoch.
// Per byte: accept, then per hash probe a table read followed by a code memory
// read and compare, then one code at a time into the output register.
// The first byte of a text needs no probe; each collision adds another probe.
// The table stays at most half full, so a probe run always ends.
// The input is taken again as soon as the codes sit in the output register;
// a stalled receiver holds the block only while codes wait behind that register.
// Reset empties the prefix and the dictionary, sets dictionary_limit to 4096 and
// runs a clearing pass over the table with s_axis_tready low. The same pass runs
// after the last code of every 255th text that used the dictionary, when the
// epoch wraps.
// dictionary_limit lives at APB byte address 0; write it only while idle.
module lzw_byte_compressor_unit #(
	parameter int CODE_BITS = lzwbc_pkg::CODE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lzwbc_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
	input  logic                              s_axis_tlast,   // end_of_text
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [((CODE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // [CODE_BITS-1:0] code_word
	output logic                              m_axis_tlast    // last_code
);
	import lzwbc_pkg::*;

	localparam int CB  = CODE_BITS;
	localparam int NW  = CB + 1;
	localparam int HB  = CB + 1;
	localparam int KW  = CB + 8;
	localparam int EB  = EPOCH_BITS;
	localparam int TW  = EB + CB;
	localparam int OW  = ((CB + 7) / 8) * 8;
	localparam int LW  = (NW > LIMIT_BITS) ? NW : LIMIT_BITS;
	localparam int HT_DEPTH = 1 << HB;
	localparam int DC_DEPTH = 1 << CB;

	lzwbc_state_t state_q, state_d;

	logic [LIMIT_BITS-1:0] limit_q;
	logic [CB-1:0]         prefix_q;
	logic                  pvalid_q;
	logic [NW-1:0]         nf_q;
	logic [KW-1:0]         key_q;
	logic [7:0]            byte_q;
	logic                  eot_q;
	logic [HB-1:0]         addr_q;
	logic [HB-1:0]         clr_q;
	logic                  clr_pend_q;
	logic [EB-1:0]         epoch_q;
	logic                  e1_v_q, e2_v_q;
	logic [CB-1:0]         e1_code_q, e2_code_q;
	logic                  out_v_q, out_last_q;
	logic [CB-1:0]         out_code_q;

	// table slot: epoch tag above the code
	logic [TW-1:0] ht_mem [HT_DEPTH];
	logic [KW-1:0] dc_mem [DC_DEPTH];
	logic [TW-1:0] ht_rd_q;
	logic [KW-1:0] dc_rd_q;

	logic          accept, out_free, out_load, live, hit, collide, can_add;
	logic [KW-1:0] in_key;
	logic [HB-1:0] in_hash;
	logic [CB-1:0] slot_code;
	logic [EB-1:0] slot_tag;
	logic          ht_re, ht_we, dc_we;
	logic [HB-1:0] ht_raddr, ht_waddr;
	logic [TW-1:0] ht_wdata;

	assign pready        = 1'b1;
	assign prdata        = (paddr == REG_DICT_LIMIT) ? 32'(limit_q) : 32'd0;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_v_q || m_axis_tready;
	assign out_load      = (state_q == ST_EMIT) && out_free;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OW'(out_code_q);

	assign in_key  = {prefix_q, s_axis_tdata};
	assign in_hash = in_key[HB-1:0] ^ HB'(in_key[KW-1:HB]);

	assign slot_code = ht_rd_q[CB-1:0];
	assign slot_tag  = ht_rd_q[TW-1:CB];

	// slot is meaningful only if written in this text; the epoch is never zero
	assign live    = (slot_tag == epoch_q);
	assign hit     = live && (dc_rd_q == key_q);
	assign collide = live && (dc_rd_q != key_q);
	assign can_add = (LW'(nf_q) < LW'(limit_q)) && (LW'(nf_q) < LW'(DC_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (pvalid_q) state_d = ST_HT;
					else if (s_axis_tlast) state_d = ST_EMIT;
				end
			end
			ST_HT: state_d = ST_DIC;
			ST_DIC: begin
				if (collide) state_d = ST_HT;
				else if (hit && !eot_q) state_d = ST_IDLE;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && !(e1_v_q && e2_v_q))
					state_d = clr_pend_q ? ST_CLR : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ht_re    = 1'b0;
		ht_we    = 1'b0;
		dc_we    = 1'b0;
		ht_raddr = in_hash;
		ht_waddr = addr_q;
		ht_wdata = {epoch_q, nf_q[CB-1:0]};
		unique case (state_q)
			ST_CLR: begin
				ht_we    = 1'b1;
				ht_waddr = clr_q;
				ht_wdata = '0;
			end
			ST_IDLE: ht_re = accept && pvalid_q;
			ST_DIC: begin
				ht_raddr = addr_q + HB'(1);
				ht_re    = collide;
				ht_we    = !live && can_add;
				dc_we    = !live && can_add;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ht_re) ht_rd_q <= ht_mem[ht_raddr];
		if (ht_we) ht_mem[ht_waddr] <= ht_wdata;
		if (state_q == ST_HT) dc_rd_q <= dc_mem[slot_code];
		if (dc_we) dc_mem[nf_q[CB-1:0]] <= key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			limit_q    <= LIMIT_BITS'(LIMIT_RESET);
			prefix_q   <= '0;
			pvalid_q   <= 1'b0;
			nf_q       <= NW'(FIRST_ENTRY);
			key_q      <= '0;
			byte_q     <= '0;
			eot_q      <= 1'b0;
			addr_q     <= '0;
			clr_q      <= '0;
			clr_pend_q <= 1'b0;
			epoch_q    <= EB'(1);
			e1_v_q     <= 1'b0;
			e2_v_q     <= 1'b0;
			e1_code_q  <= '0;
			e2_code_q  <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			out_code_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == REG_DICT_LIMIT)
				limit_q <= pwdata[LIMIT_BITS-1:0];
			if (out_load) begin
				out_v_q <= e1_v_q || e2_v_q;
				if (e1_v_q) begin
					out_code_q <= e1_code_q;
					out_last_q <= 1'b0;
					e1_v_q     <= 1'b0;
				end else begin
					out_code_q <= e2_code_q;
					out_last_q <= 1'b1;
					e2_v_q     <= 1'b0;
				end
			end else if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + HB'(1);
					if (clr_q == '1) clr_pend_q <= 1'b0;
				end
				ST_IDLE: begin
					if (accept) begin
						byte_q <= s_axis_tdata;
						eot_q  <= s_axis_tlast;
						key_q  <= in_key;
						addr_q <= in_hash;
						if (!pvalid_q) begin
							if (s_axis_tlast) begin
								e2_v_q    <= 1'b1;
								e2_code_q <= CB'(s_axis_tdata);
								nf_q      <= NW'(FIRST_ENTRY);
							end else begin
								prefix_q <= CB'(s_axis_tdata);
								pvalid_q <= 1'b1;
							end
						end
					end
				end
				ST_DIC: begin
					if (collide) begin
						addr_q <= addr_q + HB'(1);
					end else begin
						if (hit) begin
							prefix_q <= slot_code;
							if (eot_q) begin
								e2_v_q    <= 1'b1;
								e2_code_q <= slot_code;
							end
						end else begin
							e1_v_q    <= 1'b1;
							e1_code_q <= prefix_q;
							prefix_q  <= CB'(byte_q);
							if (can_add && !eot_q) nf_q <= nf_q + NW'(1);
							if (eot_q) begin
								e2_v_q    <= 1'b1;
								e2_code_q <= CB'(byte_q);
							end
						end
						if (eot_q) begin
							pvalid_q <= 1'b0;
							nf_q     <= NW'(FIRST_ENTRY);
							// epoch wrap: old tags would come back, so wipe the table
							if (epoch_q == '1) begin
								epoch_q    <= EB'(1);
								clr_pend_q <= 1'b1;
							end else begin
								epoch_q <= epoch_q + EB'(1);
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/lzwbc_checker.sv
module lzwbc_checker #(
	parameter int CODE_BITS = lzwbc_pkg::CODE_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [((CODE_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic [31:0]                    prdata
);
	import lzwbc_pkg::*;

	// a waiting code is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("code word changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata >> CODE_BITS) == '0))
		else $error("code word exceeds code width");

	a_reg_width: assert property (@(posedge clk) disable iff (!arst_n)
		(prdata >> LIMIT_BITS) == 32'd0)
		else $error("limit register readback too wide");

endmodule

bind lzw_byte_compressor_unit lzwbc_checker #(.CODE_BITS(CODE_BITS)) u_lzwbc_checker (.*);
